FILE: src/byterun1_decoder_macros.svh
// Assertion helpers for the run-length decoder.
// Both forms take a label, the clock, the active-low reset, a condition and a consequence.
`ifndef BYTERUN1_DECODER_MACROS_SVH
`define BYTERUN1_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the condition.
`define BR1_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("byterun1 assertion failed");

// The consequence must hold in the cycle after the condition.
`define BR1_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("byterun1 assertion failed");

`else

`define BR1_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define BR1_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

FILE: src/br1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package br1_pkg;

    localparam int unsigned BYTES_PER_RESULT_DEF = 8;
    localparam int unsigned MAX_RESULT_BYTES     = 8;
    localparam int unsigned MAX_RESULTS          = 16;
    localparam int unsigned QUEUE_DEPTH_DEF      = 2;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned OUT_BYTES_W = 64;
    localparam int unsigned COUNT_W     = 4;

    localparam logic [7:0] LITERAL_MAX     = 8'd127;
    localparam logic [7:0] BAD_HEADER_BYTE = 8'd128;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COMPRESSED   = 1'b0,
        CFG_OUTPUT_LIMIT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_OVERFLOW   = 2'd2,
        ST_TRUNCATED  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       body_end;
    } t_in_item;

    typedef struct packed {
        logic [OUT_BYTES_W-1:0] out_bytes;
        logic [COUNT_W-1:0]     byte_count;
        logic                   run_last;
        logic                   end_of_body;
        t_status                status;
    } t_out_item;

    // One classified input byte: emit copies of data in chunks, then an
    // optional zero-count tail result. Status and end flag go on the last result.
    typedef struct packed {
        logic [7:0]         data;
        logic [7:0]         emit;
        logic [COUNT_W-1:0] chunk;
        logic               tail;
        t_status            status;
        logic               eob;
    } t_cmd;

endpackage

`default_nettype wire

FILE: src/br1_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface br1_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: src/br1_front.sv
`timescale 1ns / 1ps
`default_nettype none

module br1_front #(
    parameter int unsigned BYTES_PER_RESULT = br1_pkg::BYTES_PER_RESULT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    br1_stream_if.sink                          i_in,
    input  wire logic                           i_cfg_we,
    input  wire logic [br1_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [br1_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                           i_queue_full,
    output logic                                o_push,
    output br1_pkg::t_cmd                       o_cmd
);

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_LITERAL,
        MODE_REPEAT
    } t_mode;

    // Above this many bytes a repeat would need too many results at the
    // configured width, so it falls back to full-width results.
    localparam logic [8:0] SPLIT_AT = 9'(br1_pkg::MAX_RESULTS * BYTES_PER_RESULT);

    t_mode       r_mode, n_mode;
    logic [7:0]  r_left, n_left;
    logic [31:0] r_written, n_written;
    logic        r_err, n_err;
    logic        r_compressed;
    logic [31:0] r_limit;

    logic        fire;
    logic        end_in;
    logic [7:0]  b;
    logic        room_ok;
    logic [31:0] room;
    logic [7:0]  emit_rep;
    logic [7:0]  lit_left;
    logic        err;
    logic        push;
    br1_pkg::t_cmd cmd;

    assign i_in.ready = !i_queue_full;
    assign fire       = i_in.valid && !i_queue_full;
    assign b          = i_in.payload.in_byte;
    assign end_in     = i_in.payload.body_end;

    assign room_ok  = r_written < r_limit;
    assign room     = r_limit - r_written;
    assign lit_left = (r_left != 8'd0) ? r_left - 8'd1 : 8'd0;

    always_comb begin
        if (!room_ok) begin
            emit_rep = 8'd0;
        end else if (room < {24'd0, r_left}) begin
            emit_rep = room[7:0];
        end else begin
            emit_rep = r_left;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_left    = r_left;
        n_written = r_written;
        n_err     = r_err;
        err       = 1'b0;
        push      = 1'b0;
        cmd.data   = b;
        cmd.emit   = 8'd0;
        cmd.chunk  = br1_pkg::COUNT_W'(1);
        cmd.tail   = 1'b0;
        cmd.status = br1_pkg::ST_OK;
        cmd.eob    = end_in;

        if (r_err) begin
            // Dropping bytes until the body ends; the end still reports.
            if (end_in) begin
                cmd.tail = 1'b1;
                push     = 1'b1;
            end
        end else if (!r_compressed) begin
            cmd.emit = 8'd1;
            push     = 1'b1;
        end else begin
            case (r_mode)
                MODE_LITERAL: begin
                    push = 1'b1;
                    if (room_ok) begin
                        cmd.emit  = 8'd1;
                        n_written = r_written + 32'd1;
                    end else begin
                        cmd.tail   = 1'b1;
                        cmd.status = br1_pkg::ST_OVERFLOW;
                        err        = 1'b1;
                    end
                    n_left = lit_left;
                    if (lit_left == 8'd0) begin
                        n_mode = MODE_HEADER;
                    end else if (end_in && !err) begin
                        cmd.tail   = 1'b1;
                        cmd.status = br1_pkg::ST_TRUNCATED;
                    end
                end
                MODE_REPEAT: begin
                    push      = 1'b1;
                    cmd.emit  = emit_rep;
                    cmd.chunk = ({1'b0, emit_rep} > SPLIT_AT)
                              ? br1_pkg::COUNT_W'(br1_pkg::MAX_RESULT_BYTES)
                              : br1_pkg::COUNT_W'(BYTES_PER_RESULT);
                    n_written = r_written + {24'd0, emit_rep};
                    if (emit_rep != r_left) begin
                        err        = 1'b1;
                        cmd.status = br1_pkg::ST_OVERFLOW;
                        cmd.tail   = (emit_rep == 8'd0);
                    end
                    n_mode = MODE_HEADER;
                    n_left = 8'd0;
                end
                default: begin
                    if (b == br1_pkg::BAD_HEADER_BYTE) begin
                        cmd.tail   = 1'b1;
                        cmd.status = br1_pkg::ST_BAD_HEADER;
                        err        = 1'b1;
                        push       = 1'b1;
                    end else if (b <= br1_pkg::LITERAL_MAX) begin
                        n_mode = MODE_LITERAL;
                        n_left = b + 8'd1;
                    end else begin
                        // Repeat count is 257 minus the header byte.
                        n_mode = MODE_REPEAT;
                        n_left = ~b + 8'd2;
                    end
                    if (end_in && !err) begin
                        cmd.tail   = 1'b1;
                        cmd.status = br1_pkg::ST_TRUNCATED;
                        push       = 1'b1;
                    end
                end
            endcase
        end

        if (err && !end_in) begin
            n_err = 1'b1;
        end
        if (end_in) begin
            n_mode    = MODE_HEADER;
            n_left    = 8'd0;
            n_written = 32'd0;
            n_err     = 1'b0;
        end
        if (!fire) begin
            n_mode    = r_mode;
            n_left    = r_left;
            n_written = r_written;
            n_err     = r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_HEADER;
            r_left       <= 8'd0;
            r_written    <= 32'd0;
            r_err        <= 1'b0;
            r_compressed <= 1'b1;
            r_limit      <= 32'd0;
        end else begin
            r_mode    <= n_mode;
            r_left    <= n_left;
            r_written <= n_written;
            r_err     <= n_err;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    br1_pkg::CFG_COMPRESSED:   r_compressed <= i_cfg_wdata[0];
                    br1_pkg::CFG_OUTPUT_LIMIT: r_limit      <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign o_push = fire && push;
    assign o_cmd  = cmd;

endmodule

`default_nettype wire

FILE: src/br1_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "byterun1_decoder_macros.svh"

module br1_queue #(
    parameter int unsigned DEPTH = br1_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire br1_pkg::t_cmd i_push_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output br1_pkg::t_cmd      o_pop_data,
    output logic               o_empty
);

    // DEPTH must be a power of two so the pointers wrap on their own; the block does not check it.
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    br1_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // The front only classifies a byte when there is room for its command.
    `BR1_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full)
    `BR1_ASSERT_SAME(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

`default_nettype wire

FILE: src/br1_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "byterun1_decoder_macros.svh"

module br1_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire br1_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_pop,
    br1_stream_if.source       o_out
);

    logic                        r_cur_valid;
    br1_pkg::t_cmd               r_cur;
    logic [7:0]                  r_left;
    logic                        r_out_valid;
    br1_pkg::t_out_item          r_out;

    logic                        step;
    logic                        is_data;
    logic [br1_pkg::COUNT_W-1:0] take;
    logic [br1_pkg::COUNT_W-1:0] count;
    logic [7:0]                  new_left;
    logic                        last;
    br1_pkg::t_out_item          res;

    assign step    = r_cur_valid && (!r_out_valid || o_out.ready);
    assign is_data = (r_left != 8'd0);
    assign take    = (r_left < {4'd0, r_cur.chunk}) ? r_left[br1_pkg::COUNT_W-1:0]
                                                    : r_cur.chunk;
    assign count    = is_data ? take : '0;
    assign new_left = r_left - {4'd0, count};
    assign last     = is_data ? ((new_left == 8'd0) && !r_cur.tail) : 1'b1;

    always_comb begin
        for (int i = 0; i < int'(br1_pkg::MAX_RESULT_BYTES); i++) begin
            res.out_bytes[i*8 +: 8] = (i < int'(count)) ? r_cur.data : 8'h00;
        end
        res.byte_count  = count;
        res.run_last    = last;
        res.end_of_body = last && r_cur.eob;
        res.status      = last ? r_cur.status : br1_pkg::ST_OK;
    end

    // A new command is taken in the cycle the current one gives its last result.
    assign o_pop = !i_cmd_empty && (!r_cur_valid || (step && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
            end else if (step && last) begin
                r_cur_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur  <= i_cmd;
            r_left <= i_cmd.emit;
        end else if (step) begin
            r_left <= new_left;
        end
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    `BR1_ASSERT_SAME(a_eob_is_last, i_clk, i_rst_n, r_out_valid && r_out.end_of_body, r_out.run_last)
    `BR1_ASSERT_SAME(a_status_on_last, i_clk, i_rst_n, r_out_valid && (r_out.status != br1_pkg::ST_OK), r_out.run_last)
    `BR1_ASSERT_SAME(a_count_range, i_clk, i_rst_n, r_out_valid, r_out.byte_count <= 4'd8)
    `BR1_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, step && !last, r_cur_valid)

endmodule

`default_nettype wire

FILE: src/byterun1_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                                          Transfer
// i_in      in         in_byte, body_end                                valid && ready
// o_out     out        out_bytes, byte_count, run_last, end_of_body,    valid && ready
//                      status
// i_cfg_*   in         register index and 32-bit write data             i_cfg_we
//
// The front takes one compressed byte per cycle while the command queue has room
// and turns it into at most one command; a header byte alone gives no command.
// The back gives one result per cycle from the head command while o_out is not
// stalled: n decoded bytes give ceil(n / chunk) results, plus one when the command
// ends in a zero-count status result, so long runs fill the queue and hold i_in.ready
// low until the back catches up.
// Each result is built from the registered head command and held in the output
// register, which takes the next result in the same cycle the current one transfers.
// Reset is synchronous and active low; it clears the decode state, queue and
// output register and loads the register defaults (decoding on, limit zero).

module byterun1_decoder #(
    parameter int unsigned BYTES_PER_RESULT = br1_pkg::BYTES_PER_RESULT_DEF,
    parameter int unsigned QUEUE_DEPTH      = br1_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    br1_stream_if.sink                           i_in,
    br1_stream_if.source                         o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [br1_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [br1_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic          queue_full;
    logic          queue_empty;
    logic          push;
    logic          pop;
    br1_pkg::t_cmd push_cmd;
    br1_pkg::t_cmd head_cmd;

    // Front: register file, decode state and classification of each byte.
    br1_front #(
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Short queue so the front keeps taking bytes while the back expands a run.
    br1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_pop_data  (head_cmd),
        .o_empty     (queue_empty)
    );

    // Back: splits each command into results and drives the output register.
    br1_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (queue_empty),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the run-length body decoder.
//
// Each byte transfer on the input channel is fed to a software decoder in this
// module. That decoder keeps its own copy of the decode state and of the two
// registers. Every result it predicts is queued, and each result transfer on the
// output channel is compared field by field with the oldest queued entry.
//
// The stimulus has two parts. The first is a short table of bytes that
// covers these cases:
//   - the bad header byte;
//   - overflow of the output limit on literal and on repeat runs;
//   - a body that ends on a header or inside a literal run;
//   - the longest literal and repeat runs;
//   - pass-through mode.
// Where a row's single result is obvious, the table carries the expected result
// itself. Otherwise the predictor supplies it. The second part is random bodies
// under random register settings. Most of these bodies are well-formed runs with
// random content. The rest are bodies cut short and raw junk.

module testbench;
    import br1_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 200;
    localparam int unsigned DRAIN_CYCLES  = 16;   // covers the front, queue and output stage
    localparam int unsigned SETTLE_LIMIT  = 5000;
    localparam int unsigned REPORT_LIMIT  = 40;

    typedef enum logic [1:0] {
        DM_HEADER,
        DM_LITERAL,
        DM_REPEAT
    } t_decode_mode;

    // How a row of the directed table is handled.
    typedef enum logic [1:0] {
        ROW_PREDICT,    // results come from the predictor
        ROW_NONE,       // the byte gives no result
        ROW_ONE,        // the byte gives exactly the result typed in the row
        ROW_SETREG      // register write, done while the block is idle
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_in_item    item;
        t_cfg_reg    reg_index;
        logic [31:0] reg_value;
        t_out_item   result;
    } t_stim_row;

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    br1_stream_if #(.t_payload(t_in_item))  byte_in ();
    br1_stream_if #(.t_payload(t_out_item)) result_out ();

    byterun1_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (byte_in),
        .o_out       (result_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // The predictor's copy of the registers and of the decode state.
    logic         cfg_compressed = 1'b1;
    logic [31:0]  cfg_limit      = 32'd0;
    t_decode_mode dec_mode       = DM_HEADER;
    logic [7:0]   run_left       = 8'd0;
    logic [31:0]  bytes_out      = 32'd0;
    logic         err_latched    = 1'b0;

    t_out_item step_results[$];      // results of the byte being decoded
    t_out_item expected_results[$];  // results still owed by the block
    t_stim_row rows[$];              // the directed table

    bit          gaps_on = 1'b1;
    int unsigned mismatch_count  = 0;
    int unsigned items_sent      = 0;
    int unsigned bodies_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned settings_made   = 0;
    int unsigned status_tally[4] = '{0, 0, 0, 0};

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The run limit. It is generous: the slowest correct run takes well under
    // a tenth of it.
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LIMIT)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void add_result(input logic [63:0] data, input int unsigned count,
                                       input t_status st);
        t_out_item r;
        r.out_bytes   = data;
        r.byte_count  = COUNT_W'(count);
        r.run_last    = 1'b0;
        r.end_of_body = 1'b0;
        r.status      = st;
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic void add_row(input t_stim_row row);
        rows.insert(rows.size(), row);
    endfunction

    // Decodes one accepted byte into step_results and advances the state.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        bit          failed;
        int unsigned want, room, emit, chunk, done, piece, k;
        logic [63:0] repeated;
        failed = 1'b0;
        step_results.delete();
        if (err_latched) begin
            // After an error, everything up to the body end is dropped.
            if (last)
                add_result('0, 0, ST_OK);
        end else if (!cfg_compressed) begin
            add_result({56'd0, b}, 1, ST_OK);
        end else if (dec_mode == DM_LITERAL) begin
            if (bytes_out < cfg_limit) begin
                add_result({56'd0, b}, 1, ST_OK);
                bytes_out++;
            end else begin
                add_result('0, 0, ST_OVERFLOW);
                failed = 1'b1;
            end
            if (run_left != 0)
                run_left--;
            if (run_left == 0)
                dec_mode = DM_HEADER;
            // A body end inside a literal run leaves the run open.
            if (last && !failed && dec_mode != DM_HEADER)
                add_result('0, 0, ST_TRUNCATED);
        end else if (dec_mode == DM_REPEAT) begin
            want  = run_left;
            room  = (bytes_out < cfg_limit) ? cfg_limit - bytes_out : 0;
            emit  = (want < room) ? want : room;
            chunk = BYTES_PER_RESULT_DEF;
            if (chunk < 1 || chunk > MAX_RESULT_BYTES || (emit + chunk - 1) / chunk > MAX_RESULTS)
                chunk = MAX_RESULT_BYTES;
            done = 0;
            while (done < emit) begin
                piece    = (emit - done > chunk) ? chunk : emit - done;
                repeated = '0;
                for (k = 0; k < piece; k++)
                    repeated[8*k +: 8] = b;
                add_result(repeated, piece, ST_OK);
                done += piece;
            end
            bytes_out += emit;
            if (emit < want) begin
                // Overflow marks the last data result, or a result of its own if
                // no data was emitted.
                failed = 1'b1;
                if (step_results.size() != 0)
                    step_results[step_results.size() - 1].status = ST_OVERFLOW;
                else
                    add_result('0, 0, ST_OVERFLOW);
            end
            dec_mode = DM_HEADER;
            run_left = 8'd0;
        end else begin
            if (b == BAD_HEADER_BYTE) begin
                add_result('0, 0, ST_BAD_HEADER);
                failed = 1'b1;
            end else if (b <= LITERAL_MAX) begin
                dec_mode = DM_LITERAL;
                run_left = b + 8'd1;
            end else begin
                dec_mode = DM_REPEAT;
                run_left = 8'd1 - b;    // 257 - b, modulo 256
            end
            if (last && !failed)
                add_result('0, 0, ST_TRUNCATED);
        end

        if (step_results.size() != 0) begin
            step_results[step_results.size() - 1].run_last    = 1'b1;
            step_results[step_results.size() - 1].end_of_body = last;
        end
        if (failed && !last)
            err_latched = 1'b1;
        if (last) begin
            dec_mode    = DM_HEADER;
            run_left    = 8'd0;
            bytes_out   = 32'd0;
            err_latched = 1'b0;
        end
    endfunction

    // Offers one byte, waits for its transfer and queues what it must produce.
    // The gap before the byte lowers valid, so a gap can fall between any two bytes.
    task automatic send_byte(input t_in_item item, input t_row_kind kind,
                             input t_out_item typed);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            byte_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        byte_in.valid   <= 1'b1;
        byte_in.payload <= item;
        do @(posedge clk); while (byte_in.ready !== 1'b1);
        decode_byte(item.in_byte, item.body_end);
        if (kind == ROW_PREDICT) begin
            foreach (step_results[k])
                expected_results.insert(expected_results.size(), step_results[k]);
        end else if (kind == ROW_ONE) begin
            expected_results.insert(expected_results.size(), typed);
        end
        items_sent++;
        if (item.body_end)
            bodies_sent++;
    endtask

    // Stops sending and waits until every owed result has arrived. It then lets the
    // pipeline drain, because a header byte can still be in flight with nothing owed.
    task automatic settle_outputs();
        int unsigned waited;
        byte_in.valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
            expected_results.delete();
        end
    endtask

    task automatic write_register(input t_cfg_reg idx, input logic [31:0] value);
        settle_outputs();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_COMPRESSED)
            cfg_compressed = value[0];
        else
            cfg_limit = value;
        settings_made++;
    endtask

    function automatic t_out_item one_result(input logic [63:0] data, input int unsigned count,
                                             input logic eob, input t_status st);
        t_out_item r;
        r.out_bytes   = data;
        r.byte_count  = COUNT_W'(count);
        r.run_last    = 1'b1;
        r.end_of_body = eob;
        r.status      = st;
        return r;
    endfunction

    function automatic t_stim_row byte_row(input t_row_kind kind, input logic [7:0] b,
                                           input logic last, input t_out_item typed);
        t_stim_row row;
        row.kind      = kind;
        row.item      = '{in_byte: b, body_end: last};
        row.reg_index = CFG_COMPRESSED;
        row.reg_value = '0;
        row.result    = typed;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input t_cfg_reg idx, input logic [31:0] value);
        t_stim_row row;
        row.kind      = ROW_SETREG;
        row.item      = '0;
        row.reg_index = idx;
        row.reg_value = value;
        row.result    = '0;
        return row;
    endfunction

    // One random body. Most bodies are well-formed literal and repeat runs. Some
    // of these are cut short at a random byte. The rest are junk bytes that
    // often include the bad header.
    task automatic send_random_body();
        logic [7:0]  body[$];
        int unsigned shape, len, cut;
        shape = $urandom_range(0, 19);
        if (shape < 16) begin
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(0, 1) == 0) begin
                    len = ($urandom_range(0, 29) == 0) ? 128 : $urandom_range(1, 8);
                    body.insert(body.size(), 8'(len - 1));
                    repeat (len) body.insert(body.size(), 8'($urandom));
                end else begin
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 128)
                                                      : $urandom_range(2, 10);
                    body.insert(body.size(), 8'(257 - len));
                    body.insert(body.size(), 8'($urandom));
                end
            end
            if (shape >= 13) begin
                cut = $urandom_range(1, body.size());
                while (body.size() > cut)
                    void'(body.pop_back());
            end
        end else begin
            repeat ($urandom_range(1, 12))
                body.insert(body.size(),
                            ($urandom_range(0, 4) == 0) ? BAD_HEADER_BYTE : 8'($urandom));
        end
        foreach (body[i])
            send_byte('{in_byte: body[i], body_end: (i == body.size() - 1)}, ROW_PREDICT, '0);
    endtask

    // The output side stalls in bursts of random length while gaps are on.
    initial begin : result_stalls
        int unsigned stall_left;
        stall_left       = 0;
        result_out.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left != 0) begin
                stall_left--;
                if (stall_left == 0)
                    result_out.ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4);
                result_out.ready <= 1'b0;
            end else begin
                result_out.ready <= 1'b1;
            end
        end
    end

    // Each result transfer is compared with the oldest expectation.
    always @(posedge clk) begin : check_results
        t_out_item got, oldest;
        if (rst_n && result_out.valid && result_out.ready) begin
            got = result_out.payload;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result: bytes %h count %0d status %0d",
                                          got.out_bytes, got.byte_count, got.status));
            end else begin
                oldest = expected_results.pop_front();
                results_checked++;
                status_tally[oldest.status]++;
                if (got.out_bytes !== oldest.out_bytes)
                    report_mismatch($sformatf("out_bytes %h, expected %h",
                                              got.out_bytes, oldest.out_bytes));
                if (got.byte_count !== oldest.byte_count)
                    report_mismatch($sformatf("byte_count %0d, expected %0d",
                                              got.byte_count, oldest.byte_count));
                if (got.run_last !== oldest.run_last)
                    report_mismatch($sformatf("run_last %b, expected %b",
                                              got.run_last, oldest.run_last));
                if (got.end_of_body !== oldest.end_of_body)
                    report_mismatch($sformatf("end_of_body %b, expected %b",
                                              got.end_of_body, oldest.end_of_body));
                if (got.status !== oldest.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, oldest.status));
            end
        end
    end

    initial begin : stimulus
        int unsigned directed_items;
        logic [31:0] limit_pick;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_COMPRESSED;
        cfg_wdata          = '0;
        byte_in.valid      = 1'b0;
        byte_in.payload    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: decoding on, output limit zero.
        // A bad header raises an error. Bytes after it are dropped until the body
        // end, which gives a clean result.
        add_row(byte_row(ROW_ONE, 8'h80, 1'b0, one_result('0, 0, 1'b0, ST_BAD_HEADER)));
        add_row(byte_row(ROW_NONE, 8'h55, 1'b0, '0));
        add_row(byte_row(ROW_ONE, 8'hFF, 1'b1, one_result('0, 0, 1'b1, ST_OK)));
        // With a zero limit, a literal byte and a repeat run both overflow at once.
        add_row(byte_row(ROW_NONE, 8'h00, 1'b0, '0));
        add_row(byte_row(ROW_ONE, 8'hAA, 1'b0, one_result('0, 0, 1'b0, ST_OVERFLOW)));
        add_row(byte_row(ROW_ONE, 8'h00, 1'b1, one_result('0, 0, 1'b1, ST_OK)));
        add_row(byte_row(ROW_NONE, 8'hFF, 1'b0, '0));
        add_row(byte_row(ROW_ONE, 8'h33, 1'b0, one_result('0, 0, 1'b0, ST_OVERFLOW)));
        add_row(byte_row(ROW_ONE, 8'h44, 1'b1, one_result('0, 0, 1'b1, ST_OK)));
        // Largest limit. The longest literal run is opened, and then the body ends
        // inside it.
        add_row(reg_row(CFG_OUTPUT_LIMIT, 32'hFFFF_FFFF));
        add_row(byte_row(ROW_NONE, 8'h7F, 1'b0, '0));
        add_row(byte_row(ROW_ONE, 8'h00, 1'b0, one_result(64'h00, 1, 1'b0, ST_OK)));
        add_row(byte_row(ROW_ONE, 8'hFF, 1'b0, one_result(64'hFF, 1, 1'b0, ST_OK)));
        add_row(byte_row(ROW_PREDICT, 8'h5A, 1'b1, '0));
        // The longest repeat run (128 bytes, sixteen full results), then the
        // shortest one.
        add_row(byte_row(ROW_NONE, 8'h81, 1'b0, '0));
        add_row(byte_row(ROW_PREDICT, 8'hC3, 1'b0, '0));
        add_row(byte_row(ROW_NONE, 8'hFF, 1'b0, '0));
        add_row(byte_row(ROW_PREDICT, 8'h00, 1'b0, '0));
        // Bodies that end on a literal header and on a repeat header, then one that
        // ends cleanly on the last literal of its run.
        add_row(byte_row(ROW_ONE, 8'h01, 1'b1, one_result('0, 0, 1'b1, ST_TRUNCATED)));
        add_row(byte_row(ROW_ONE, 8'hFE, 1'b1, one_result('0, 0, 1'b1, ST_TRUNCATED)));
        add_row(byte_row(ROW_NONE, 8'h00, 1'b0, '0));
        add_row(byte_row(ROW_ONE, 8'hA5, 1'b1, one_result(64'hA5, 1, 1'b1, ST_OK)));
        // A repeat of eight against a limit of five is clipped and flagged.
        add_row(reg_row(CFG_OUTPUT_LIMIT, 32'd5));
        add_row(byte_row(ROW_NONE, 8'hF9, 1'b0, '0));
        add_row(byte_row(ROW_PREDICT, 8'h11, 1'b0, '0));
        add_row(byte_row(ROW_ONE, 8'h22, 1'b1, one_result('0, 0, 1'b1, ST_OK)));
        // Pass-through mode: even the bad header byte goes straight out.
        add_row(reg_row(CFG_COMPRESSED, 32'd0));
        add_row(byte_row(ROW_ONE, 8'h80, 1'b0, one_result(64'h80, 1, 1'b0, ST_OK)));
        add_row(byte_row(ROW_ONE, 8'h7E, 1'b1, one_result(64'h7E, 1, 1'b1, ST_OK)));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_SETREG)
                write_register(rows[i].reg_index, rows[i].reg_value);
            else
                send_byte(rows[i].item, rows[i].kind, rows[i].result);
        end
        directed_items = items_sent;

        // Random part. Each round writes both registers and then sends a few bodies.
        // The last rounds run without gaps on either side.
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            write_register(CFG_COMPRESSED, {31'd0, ($urandom_range(0, 5) != 0)});
            case ($urandom_range(0, 5))
                0:       limit_pick = 32'd0;
                1:       limit_pick = 32'hFFFF_FFFF;
                2:       limit_pick = $urandom_range(1, 16);
                3:       limit_pick = $urandom_range(17, 400);
                default: limit_pick = $urandom;
            endcase
            write_register(CFG_OUTPUT_LIMIT, limit_pick);
            gaps_on = (items_sent + 60 < directed_items + RANDOM_ITEMS);
            repeat ($urandom_range(3, 6)) send_random_body();
        end

        settle_outputs();
        $display("Sent %0d bytes in %0d bodies under %0d register writes; checked %0d results.",
                 items_sent, bodies_sent, settings_made, results_checked);
        $display("Status results: %0d bad header, %0d overflow, %0d cut short.",
                 status_tally[ST_BAD_HEADER], status_tally[ST_OVERFLOW],
                 status_tally[ST_TRUNCATED]);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
